### sv/rspg_pkg.sv
// rspg_pkg: shared types and constants of the rejection-sampled permutation generator.
// Used by rspg_mod, rspg_cell and rejection_sampled_permutation_gen.
`timescale 1ns / 1ps
`default_nettype none

package rspg_pkg;

  localparam int unsigned PERM_SIZE_DEF   = 64;
  localparam int unsigned WORD_BUDGET_DEF = 256;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned ELEM_W   = 6;
  localparam int unsigned USED_W   = 16;
  localparam int unsigned STEP_W   = $clog2(WORD_W);

  // sample travelling down the cell row
  typedef struct packed {
    logic              valid;
    logic [ELEM_W-1:0] si;
    logic [ELEM_W-1:0] cnt;
  } token_t;

  typedef struct packed {
    logic flush;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_FILL,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

### sv/rspg_mod.sv
// rspg_mod: bit-serial remainder of a random word by the current bound,
// plus the rejection test. Depends on rspg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rspg_mod #(
  parameter int unsigned BOUND_W = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rspg_pkg::WORD_W-1:0] word_i,
  input  wire logic [BOUND_W-1:0]         bound_i,
  output logic                            done_o,
  output logic [BOUND_W-1:0]              rem_o,
  output logic                            reject_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [rspg_pkg::STEP_W-1:0]     step_q, step_d;
  logic [rspg_pkg::WORD_W-1:0]     word_q, word_d;
  logic [BOUND_W-1:0]              rem_q, rem_d;
  logic [BOUND_W:0]                trial;
  logic [rspg_pkg::STEP_W-1:0]     bit_idx;
  logic [rspg_pkg::WORD_W:0]       top_sum;

  assign bit_idx = rspg_pkg::STEP_W'(rspg_pkg::WORD_W - 1) - step_q;
  assign trial   = {rem_q, word_q[bit_idx]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    word_d = word_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      word_d = word_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, bound_i}) begin
        rem_d = BOUND_W'(trial - {1'b0, bound_i});
      end else begin
        rem_d = BOUND_W'(trial);
      end
      step_d = step_q + 1'b1;
      if (step_q == rspg_pkg::STEP_W'(rspg_pkg::WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rem_q  <= rem_d;
  end

  // word lies in the incomplete top block when word - rem + bound - 1 overflows 16 bits
  assign top_sum  = {1'b0, word_q} + (rspg_pkg::WORD_W + 1)'(bound_i)
                    - (rspg_pkg::WORD_W + 1)'(rem_q) - (rspg_pkg::WORD_W + 1)'(1);
  assign done_o   = done_q;
  assign rem_o    = rem_q;
  assign reject_o = top_sum[rspg_pkg::WORD_W];

endmodule

`default_nettype wire

### sv/rspg_cell.sv
// rspg_cell: one slot of the conversion row; holds one sample and its finished
// element, updates passing samples and shifts elements out. Depends on rspg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rspg_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rspg_pkg::cell_ctrl_t         ctrl_i,
  input  wire rspg_pkg::token_t             tok_i,
  output rspg_pkg::token_t                  tok_o,
  input  wire logic [rspg_pkg::ELEM_W-1:0]  elem_i,
  output logic [rspg_pkg::ELEM_W-1:0]       elem_o,
  output logic                              occ_o
);

  logic                        occ_q, occ_d;
  logic                        tvld_q, tvld_d;
  logic [rspg_pkg::ELEM_W-1:0] tsi_q, tsi_d;
  logic [rspg_pkg::ELEM_W-1:0] tcnt_q, tcnt_d;
  logic [rspg_pkg::ELEM_W-1:0] w_q, w_d;
  logic [rspg_pkg::ELEM_W-1:0] elem_q, elem_d;

  always_comb begin
    occ_d  = occ_q;
    tvld_d = tok_i.valid;
    tsi_d  = tok_i.si;
    tcnt_d = tok_i.cnt;
    w_d    = w_q;
    elem_d = elem_q;
    if (ctrl_i.shift) begin
      elem_d = elem_i;
    end
    if (tok_i.valid) begin
      if (occ_q) begin
        if (w_q <= tok_i.si) begin
          tcnt_d = tok_i.cnt + 1'b1;
        end else begin
          w_d = w_q - 1'b1;
        end
      end else begin
        // first free slot: the sample settles here
        occ_d  = 1'b1;
        w_d    = tok_i.si;
        elem_d = tok_i.si + tok_i.cnt;
        tvld_d = 1'b0;
      end
    end
    if (ctrl_i.flush) begin
      occ_d  = 1'b0;
      tvld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      tvld_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      tvld_q <= tvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tsi_q  <= tsi_d;
    tcnt_q <= tcnt_d;
    w_q    <= w_d;
    elem_q <= elem_d;
  end

  assign tok_o.valid = tvld_q;
  assign tok_o.si    = tsi_q;
  assign tok_o.cnt   = tcnt_q;
  assign elem_o      = elem_q;
  assign occ_o       = occ_q;

endmodule

`default_nettype wire

### sv/rejection_sampled_permutation_gen.sv
// rejection_sampled_permutation_gen: top level; word budget, sample position,
// control and output register. Depends on rspg_pkg, rspg_mod, rspg_cell.
//
//   port group       dir  meaning
//   start/word       in   request: random_word_i taken when start & !busy
//   busy             out  high while reducing, settling or emitting results
//   result_valid_o   out  qualifies element_o, last_o, failed_o
//
// Each accepted word keeps busy high through the 16-step remainder unit
// and a decide step, so a new word goes in only once busy is low. A budget
// failure keeps busy low and shows its result in the next cycle.
// After the final sample, the control waits while it walks the cell row,
// then PERM_SIZE results go out on consecutive cycles.
// Reset clears control state only; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module rejection_sampled_permutation_gen #(
  parameter int unsigned PERM_SIZE   = rspg_pkg::PERM_SIZE_DEF,
  parameter int unsigned WORD_BUDGET = rspg_pkg::WORD_BUDGET_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [rspg_pkg::WORD_W-1:0]  random_word_i,
  output logic                              result_valid_o,
  output logic [rspg_pkg::ELEM_W-1:0]       element_o,
  output logic                              last_o,
  output logic                              failed_o
);

  localparam int unsigned POS_W  = $clog2(PERM_SIZE + 1);
  localparam int unsigned EMIT_W = $clog2(PERM_SIZE);

  rspg_pkg::state_e            state_q, state_d;
  logic [POS_W-1:0]            pos_q, pos_d;
  logic [rspg_pkg::USED_W-1:0] used_q, used_d;
  logic [EMIT_W-1:0]           emit_q, emit_d;
  logic                        rvld_q, rvld_d;
  logic [rspg_pkg::ELEM_W-1:0] elem_q, elem_d;
  logic                        last_q, last_d;
  logic                        fail_q, fail_d;

  logic                        accept;
  logic                        exhausted;
  logic                        mod_start;
  logic                        mod_done;
  logic [POS_W-1:0]            mod_rem;
  logic                        mod_reject;
  logic [POS_W-1:0]            bound;

  rspg_pkg::cell_ctrl_t        ctrl;
  rspg_pkg::token_t            tok_in;
  rspg_pkg::token_t            tok   [PERM_SIZE+1];
  logic [rspg_pkg::ELEM_W-1:0] elems [PERM_SIZE+1];
  logic [PERM_SIZE-1:0]        occ;

  assign accept    = start && (state_q == rspg_pkg::ST_IDLE);
  assign exhausted = used_q >= rspg_pkg::USED_W'(WORD_BUDGET - 1);
  assign mod_start = accept && !exhausted;
  assign bound     = POS_W'(PERM_SIZE) - pos_q;

  rspg_mod #(
    .BOUND_W (POS_W)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start),
    .word_i   (random_word_i),
    .bound_i  (bound),
    .done_o   (mod_done),
    .rem_o    (mod_rem),
    .reject_o (mod_reject)
  );

  assign tok[0]           = tok_in;
  assign elems[PERM_SIZE] = '0;

  for (genvar k = 0; k < PERM_SIZE; k++) begin : g_cell
    rspg_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1]),
      .elem_i (elems[k+1]),
      .elem_o (elems[k]),
      .occ_o  (occ[k])
    );
  end

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    used_d       = used_q;
    emit_d       = emit_q;
    rvld_d       = 1'b0;
    elem_d       = elem_q;
    last_d       = last_q;
    fail_d       = fail_q;
    ctrl.flush   = 1'b0;
    ctrl.shift   = 1'b0;
    tok_in.valid = 1'b0;
    tok_in.si    = rspg_pkg::ELEM_W'(mod_rem);
    tok_in.cnt   = '0;
    unique case (state_q)
      rspg_pkg::ST_IDLE: begin
        if (accept) begin
          if (exhausted) begin
            rvld_d     = 1'b1;
            elem_d     = '0;
            last_d     = 1'b1;
            fail_d     = 1'b1;
            pos_d      = '0;
            used_d     = '0;
            ctrl.flush = 1'b1;
          end else begin
            used_d  = used_q + 1'b1;
            state_d = rspg_pkg::ST_MOD;
          end
        end
      end
      rspg_pkg::ST_MOD: begin
        if (mod_done) begin
          state_d = rspg_pkg::ST_IDLE;
          if (!mod_reject) begin
            tok_in.valid = 1'b1;
            pos_d        = pos_q + 1'b1;
            if (pos_q == POS_W'(PERM_SIZE - 1)) begin
              state_d = rspg_pkg::ST_FILL;
            end
          end
        end
      end
      rspg_pkg::ST_FILL: begin
        // final sample has settled once the last slot is taken
        if (occ[PERM_SIZE-1]) begin
          emit_d  = '0;
          state_d = rspg_pkg::ST_EMIT;
        end
      end
      rspg_pkg::ST_EMIT: begin
        rvld_d     = 1'b1;
        elem_d     = elems[0];
        fail_d     = 1'b0;
        last_d     = (emit_q == EMIT_W'(PERM_SIZE - 1));
        ctrl.shift = 1'b1;
        emit_d     = emit_q + 1'b1;
        if (emit_q == EMIT_W'(PERM_SIZE - 1)) begin
          ctrl.flush = 1'b1;
          pos_d      = '0;
          used_d     = '0;
          state_d    = rspg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rspg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rspg_pkg::ST_IDLE;
      pos_q   <= '0;
      used_q  <= '0;
      emit_q  <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      used_q  <= used_d;
      emit_q  <= emit_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    last_q <= last_d;
    fail_q <= fail_d;
  end

  assign busy           = (state_q != rspg_pkg::ST_IDLE);
  assign result_valid_o = rvld_q;
  assign element_o      = elem_q;
  assign last_o         = last_q;
  assign failed_o       = fail_q;

endmodule

`default_nettype wire
